@@ hdl/efs_pkg.sv @@
// Package for the error function block: exponential table, scale constants,
// datapath operation codes and the controller/datapath command and status types.
// Depends on nothing.
package efs_pkg;

  // round(e^(-1/16) * 2^32), the table step
  localparam logic [31:0] EXP_STEP   = 32'd4034748382;
  // 2/sqrt(pi) in Q.32
  localparam logic [32:0] TWO_SQRTPI = 33'd4846351620;
  // 3.5 in Q4.28: below it the power series is used
  localparam logic [31:0] SPLIT_Q28  = 32'd939524096;
  // 1.0 in Q.30
  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;

  typedef logic [256:0][32:0] exp_tab_t;
  typedef logic [4:0][32:0]   scale_tab_t;

  // e^(-k/16) in Q.32, each entry the one before times the step, rounded half up
  function automatic exp_tab_t exp_tab_f();
    exp_tab_t    tab;
    logic [64:0] p;
    int          k;
    tab[0] = 33'h1_0000_0000;
    for (k = 1; k <= 256; k++) begin
      p      = {32'b0, tab[k-1]} * {33'b0, EXP_STEP} + (65'd1 << 31);
      tab[k] = p[64:32];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_f();

  // e^(-16n) in Q.32, n = 0..4, built by repeated truncating products
  function automatic scale_tab_t scale_tab_f();
    scale_tab_t  tab;
    logic [65:0] p;
    int          n;
    tab[0] = 33'h1_0000_0000;
    for (n = 1; n <= 4; n++) begin
      p      = {33'b0, tab[n-1]} * {33'b0, EXP_TAB[256]};
      tab[n] = p[64:32];
    end
    return tab;
  endfunction

  localparam scale_tab_t SCALE_TAB = scale_tab_f();

  // datapath operations
  typedef enum logic [3:0] {
    OP_SQ  = 4'd0,   // x^2
    OP_INT = 4'd1,   // table interpolation
    OP_SCL = 4'd2,   // exponent range scale
    OP_MR  = 4'd3,   // series term times x^2
    OP_DR  = 4'd4,   // series term divide by 2i+1
    OP_T1  = 4'd5,   // |x| * e
    OP_T2  = 4'd6,   // times series sum
    OP_MAG = 4'd7,   // times 2/sqrt(pi), series result
    OP_MM  = 4'd8,   // asymptotic term times 2i-1
    OP_DM  = 4'd9,   // asymptotic term divide by x^2
    OP_P   = 4'd10,  // e times asymptotic sum
    OP_DQ  = 4'd11,  // divide by |x|
    OP_C   = 4'd12   // times 2/sqrt(pi), asymptotic result
  } op_e;

  typedef struct packed {
    op_e  op;
    logic go;    // launch the unit for op
    logic cap;   // store the unit result for op
    logic load;  // take a new argument
    logic inc;   // advance the term index
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic small_arg;  // |x| below the series limit
    logic ser_stop;   // series converged or out of terms
    logic asy_last;   // last asymptotic term
  } sts_t;

endpackage

@@ hdl/efs_mul.sv @@
// Sequential 64x64 unsigned multiplier: four 32x32 partial products,
// registered, accumulated into a 128-bit product. Depends on nothing.
module efs_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic          done_o,
  output logic [127:0]  prod_o
);

  logic [63:0]  a_q, b_q, pp_q, pp_d;
  logic [1:0]   sh_q, sh_d;
  logic [127:0] acc_q, pp_ext;
  logic [2:0]   cnt_q;
  logic         run_q, vld_q, done_q;
  logic [31:0]  sa, sb;

  // partial product select
  always_comb begin
    sa   = a_q[31:0];
    sb   = b_q[31:0];
    sh_d = 2'd0;
    case (cnt_q[1:0])
      2'd0: begin sa = a_q[31:0];  sb = b_q[31:0];  sh_d = 2'd0; end
      2'd1: begin sa = a_q[31:0];  sb = b_q[63:32]; sh_d = 2'd1; end
      2'd2: begin sa = a_q[63:32]; sb = b_q[31:0];  sh_d = 2'd1; end
      2'd3: begin sa = a_q[63:32]; sb = b_q[63:32]; sh_d = 2'd2; end
      default: begin sa = a_q[31:0]; sb = b_q[31:0]; sh_d = 2'd0; end
    endcase
    pp_d = {32'b0, sa} * {32'b0, sb};
  end

  // align the registered partial product
  always_comb begin
    case (sh_q)
      2'd0:    pp_ext = {64'b0, pp_q};
      2'd1:    pp_ext = {32'b0, pp_q, 32'b0};
      2'd2:    pp_ext = {pp_q, 64'b0};
      default: pp_ext = '0;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      vld_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == 3'd4);
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        vld_q <= 1'b0;
      end else if (run_q) begin
        vld_q <= (cnt_q != 3'd4);
        if (cnt_q == 3'd4) run_q <= 1'b0;
        else               cnt_q <= cnt_q + 3'd1;
      end else begin
        vld_q <= 1'b0;
      end
    end
  end

  // operands, partial products and accumulator
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else begin
      if (run_q && (cnt_q != 3'd4)) begin
        pp_q <= pp_d;
        sh_q <= sh_d;
      end
      if (vld_q) acc_q <= acc_q + pp_ext;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

@@ hdl/efs_div.sv @@
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on nothing.
module efs_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         go_i,
  input  logic [63:0]  dvd_i,
  input  logic [31:0]  dsr_i,
  output logic         done_o,
  output logic [63:0]  quo_o
);

  localparam int unsigned DvdW = 64;
  localparam int unsigned CntW = $clog2(DvdW);

  logic [DvdW-1:0] quo_q;
  logic [31:0]     dsr_q, rem_q;
  logic [32:0]     rem_sh, rem_n;
  logic            ge;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;

  // one shift-compare-subtract step
  always_comb begin
    rem_sh = {rem_q, quo_q[DvdW-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_n  = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CntW'(DvdW - 1));
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == CntW'(DvdW - 1)) run_q <= 1'b0;
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // dividend shifts out as quotient shifts in
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= dvd_i;
      dsr_q <= dsr_i;
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= {quo_q[DvdW-2:0], ge};
      rem_q <= rem_n[31:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ hdl/efs_datapath.sv @@
// Datapath of the error function block: argument, x^2, exponential, term and
// sum registers around the shared multiplier and divider.
// Depends on efs_pkg, efs_mul, efs_div.
module efs_datapath #(
  parameter int unsigned SERIES_TERMS     = 50,
  parameter int unsigned ASYMPTOTIC_TERMS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] x_value_i,
  input  efs_pkg::cmd_t      cmd_i,
  output efs_pkg::sts_t      sts_o,
  output logic signed [31:0] erf_value_o,
  output logic [31:0]        erfc_value_o
);

  localparam int unsigned MaxTerms = (SERIES_TERMS > ASYMPTOTIC_TERMS) ?
                                     SERIES_TERMS : ASYMPTOTIC_TERMS;
  localparam int unsigned IdxW     = $clog2(MaxTerms + 1);

  logic              neg_q;
  logic [31:0]       ax_q;
  logic [38:0]       x2_q;
  logic [63:0]       e_q, r_q, er_q;
  logic [IdxW-1:0]   idx_q;
  logic [31:0]       erf_q, erfc_q;

  logic [8:0]        k_idx, k_nxt;
  logic [27:0]       frac;
  logic [32:0]       e_lo, e_hi, diff, scale;
  logic [2:0]        nsc;
  logic [IdxW:0]     odd_p, odd_m;
  logic [63:0]       mul_a, mul_b, dvd, quo, fin_val;
  logic [31:0]       dsr, sat32, erf_n;
  logic [127:0]      prod;
  logic              mul_done, div_done, is_div;

  // table lookup for e^(-x^2), range reduced by multiples of 16
  always_comb begin
    nsc   = x2_q[38:36];
    k_idx = {1'b0, x2_q[35:28]};
    k_nxt = k_idx + 9'd1;
    frac  = x2_q[27:0];
    e_lo  = efs_pkg::EXP_TAB[k_idx];
    e_hi  = efs_pkg::EXP_TAB[k_nxt];
    diff  = e_lo - e_hi;
    scale = (nsc <= 3'd4) ? efs_pkg::SCALE_TAB[nsc] : '0;
  end

  // odd factors 2i+1 and 2i-1
  assign odd_p = {idx_q, 1'b1};
  assign odd_m = {idx_q, 1'b0} - {{IdxW{1'b0}}, 1'b1};

  // unit operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dvd   = r_q;
    dsr   = {{(32-IdxW-1){1'b0}}, odd_p};
    is_div = 1'b0;
    case (cmd_i.op)
      efs_pkg::OP_SQ:  begin mul_a = {32'b0, ax_q}; mul_b = {32'b0, ax_q}; end
      efs_pkg::OP_INT: begin mul_a = {31'b0, diff}; mul_b = {36'b0, frac}; end
      efs_pkg::OP_SCL: begin mul_a = e_q;           mul_b = {31'b0, scale}; end
      efs_pkg::OP_MR:  begin mul_a = r_q;           mul_b = {25'b0, x2_q}; end
      efs_pkg::OP_DR:  begin is_div = 1'b1; end
      efs_pkg::OP_T1:  begin mul_a = {32'b0, ax_q}; mul_b = e_q; end
      efs_pkg::OP_T2:  begin mul_a = r_q;           mul_b = er_q; end
      efs_pkg::OP_MAG: begin mul_a = r_q;  mul_b = {31'b0, efs_pkg::TWO_SQRTPI}; end
      efs_pkg::OP_MM:  begin mul_a = r_q;  mul_b = {{(63-IdxW){1'b0}}, odd_m}; end
      efs_pkg::OP_DM:  begin is_div = 1'b1; dsr = {5'b0, x2_q[38:12]}; end
      efs_pkg::OP_P:   begin mul_a = e_q;  mul_b = er_q[63] ? 64'd0 : er_q; end
      efs_pkg::OP_DQ:  begin is_div = 1'b1; dvd = {r_q[33:0], 30'b0}; dsr = ax_q; end
      efs_pkg::OP_C:   begin mul_a = r_q;  mul_b = {31'b0, efs_pkg::TWO_SQRTPI}; end
      default:         begin mul_a = '0; mul_b = '0; end
    endcase
  end

  efs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.go && !is_div),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  efs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.go && is_div),
    .dvd_i  (dvd),
    .dsr_i  (dsr),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // final saturation and sign
  always_comb begin
    fin_val = (cmd_i.op == efs_pkg::OP_MAG) ? prod[125:62] : prod[100:37];
    sat32   = (fin_val > {32'b0, efs_pkg::ONE_Q30}) ? efs_pkg::ONE_Q30 : fin_val[31:0];
    if (cmd_i.op == efs_pkg::OP_MAG) begin
      erf_n = neg_q ? (32'd0 - sat32) : sat32;
    end else begin
      erf_n = neg_q ? (sat32 - efs_pkg::ONE_Q30) : (efs_pkg::ONE_Q30 - sat32);
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= x_value_i[31];
      ax_q  <= x_value_i[31] ? (~x_value_i + 32'd1) : x_value_i;
    end
    if (cmd_i.inc) idx_q <= idx_q + IdxW'(1);
    if (cmd_i.cap) begin
      case (cmd_i.op)
        efs_pkg::OP_SQ:  x2_q <= prod[62:24];
        efs_pkg::OP_INT: e_q  <= {31'b0, e_lo} - {28'b0, prod[63:28]};
        efs_pkg::OP_SCL: begin
          e_q   <= prod[95:32];
          er_q  <= 64'h1_0000_0000;
          r_q   <= 64'h1_0000_0000;
          idx_q <= {{(IdxW-1){1'b0}}, 1'b1};
        end
        efs_pkg::OP_MR:  r_q <= prod[94:31];
        efs_pkg::OP_DR:  begin r_q <= quo; er_q <= er_q + quo; end
        efs_pkg::OP_T1:  r_q <= prod[63:0];
        efs_pkg::OP_T2:  r_q <= prod[95:32];
        efs_pkg::OP_MM:  r_q <= {prod[44:0], 19'b0};
        efs_pkg::OP_DM:  begin
          r_q  <= quo;
          er_q <= idx_q[0] ? (er_q - quo) : (er_q + quo);
        end
        efs_pkg::OP_P:   r_q <= prod[95:32];
        efs_pkg::OP_DQ:  r_q <= quo;
        efs_pkg::OP_MAG, efs_pkg::OP_C: begin
          erf_q  <= erf_n;
          erfc_q <= efs_pkg::ONE_Q30 - erf_n;
        end
        default: ;
      endcase
    end
  end

  // status
  always_comb begin
    sts_o.mul_done  = mul_done;
    sts_o.div_done  = div_done;
    sts_o.small_arg = ax_q < efs_pkg::SPLIT_Q28;
    sts_o.ser_stop  = (r_q <= {30'b0, er_q[63:30]}) || (idx_q == IdxW'(SERIES_TERMS));
    sts_o.asy_last  = idx_q == IdxW'(ASYMPTOTIC_TERMS);
  end

  assign erf_value_o  = erf_q;
  assign erfc_value_o = erfc_q;

endmodule

@@ hdl/efs_ctrl.sv @@
// Controller of the error function block: sequences unit operations, term
// loops and the result strobe. Depends on efs_pkg.
module efs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  efs_pkg::sts_t sts_i,
  output efs_pkg::cmd_t cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_SQ   = 16'h0002,
    S_INT  = 16'h0004,
    S_SCL  = 16'h0008,
    S_MR   = 16'h0010,
    S_DR   = 16'h0020,
    S_CHK  = 16'h0040,
    S_T1   = 16'h0080,
    S_T2   = 16'h0100,
    S_MAG  = 16'h0200,
    S_MM   = 16'h0400,
    S_DM   = 16'h0800,
    S_P    = 16'h1000,
    S_DQ   = 16'h2000,
    S_C    = 16'h4000,
    S_OUT  = 16'h8000
  } state_e;

  state_e state_q, state_d, succ;
  logic   issued_q, issued_d, op_st, unit_done;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    cmd_o    = '0;
    op_st    = 1'b1;
    succ     = S_IDLE;
    case (state_q)
      S_IDLE: begin
        op_st = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SQ;
        end
      end
      S_SQ:  begin cmd_o.op = efs_pkg::OP_SQ;  succ = S_INT; end
      S_INT: begin cmd_o.op = efs_pkg::OP_INT; succ = S_SCL; end
      S_SCL: begin cmd_o.op = efs_pkg::OP_SCL; succ = sts_i.small_arg ? S_MR : S_MM; end
      S_MR:  begin cmd_o.op = efs_pkg::OP_MR;  succ = S_DR; end
      S_DR:  begin cmd_o.op = efs_pkg::OP_DR;  succ = S_CHK; end
      S_CHK: begin
        op_st = 1'b0;
        if (sts_i.ser_stop) begin
          state_d = S_T1;
        end else begin
          cmd_o.inc = 1'b1;
          state_d   = S_MR;
        end
      end
      S_T1:  begin cmd_o.op = efs_pkg::OP_T1;  succ = S_T2; end
      S_T2:  begin cmd_o.op = efs_pkg::OP_T2;  succ = S_MAG; end
      S_MAG: begin cmd_o.op = efs_pkg::OP_MAG; succ = S_OUT; end
      S_MM:  begin cmd_o.op = efs_pkg::OP_MM;  succ = S_DM; end
      S_DM:  begin cmd_o.op = efs_pkg::OP_DM;  succ = sts_i.asy_last ? S_P : S_MM; end
      S_P:   begin cmd_o.op = efs_pkg::OP_P;   succ = S_DQ; end
      S_DQ:  begin cmd_o.op = efs_pkg::OP_DQ;  succ = S_C; end
      S_C:   begin cmd_o.op = efs_pkg::OP_C;   succ = S_OUT; end
      S_OUT: begin op_st = 1'b0; state_d = S_IDLE; end
      default: begin op_st = 1'b0; state_d = S_IDLE; end
    endcase

    // launch once, then wait for the unit that op uses
    unit_done = ((cmd_o.op == efs_pkg::OP_DR) || (cmd_o.op == efs_pkg::OP_DM) ||
                 (cmd_o.op == efs_pkg::OP_DQ)) ? sts_i.div_done : sts_i.mul_done;
    if (op_st) begin
      if (!issued_q) begin
        cmd_o.go = 1'b1;
        issued_d = 1'b1;
      end else if (unit_done) begin
        cmd_o.cap = 1'b1;
        issued_d  = 1'b0;
        state_d   = succ;
        if ((state_q == S_DM) && !sts_i.asy_last) cmd_o.inc = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

`ifndef NO_ASSERTIONS
  a_done_only_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_i.mul_done || sts_i.div_done) |-> issued_q)
    else $error("unit finished without a launch");
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sts_i.mul_done && sts_i.div_done))
    else $error("both units finished together");
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("result strobe not followed by idle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("request not taken up");
`endif

endmodule

@@ hdl/error_function_series.sv @@
// Top level of the error function block: controller and datapath.
// Depends on efs_pkg, efs_ctrl, efs_datapath.
//
// Computes erf(x) (Q2.30, signed) and erfc(x) (Q2.30, unsigned) for one Q4.28
// argument per request. A request is taken when start is high and busy is low;
// done_o is high for exactly one cycle with the results, and the receiver must
// take them then. One item at a time is processed. Time per item is set by the
// shared multiplier and the shared radix-2 divider: for |x| < 3.5 it grows with the
// number N of series terms used (1 to SERIES_TERMS); for |x| >= 3.5 it grows with
// ASYMPTOTIC_TERMS.
module error_function_series #(
  parameter int unsigned SERIES_TERMS     = 50,
  parameter int unsigned ASYMPTOTIC_TERMS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] x_value_i,
  output logic               done_o,
  output logic signed [31:0] erf_value_o,
  output logic [31:0]        erfc_value_o
);

  efs_pkg::cmd_t cmd;
  efs_pkg::sts_t sts;

  efs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  efs_datapath #(
    .SERIES_TERMS     (SERIES_TERMS),
    .ASYMPTOTIC_TERMS (ASYMPTOTIC_TERMS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .x_value_i    (x_value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .erf_value_o  (erf_value_o),
    .erfc_value_o (erfc_value_o)
  );

endmodule

@@ test/error_function_series_tb.sv @@
// Testbench for error_function_series: drives Q4.28 arguments through the
// start/busy request handshake and checks erf/erfc against a bit-exact predictor.
// Depends on the error_function_series RTL only.

module error_function_series_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SERIES_TERMS     = 50;
  localparam int unsigned ASYMPTOTIC_TERMS = 12;
  localparam logic [63:0] EXP_STEP_Q32     = 64'd4034748382;
  localparam logic [63:0] TWO_SQRTPI_Q32   = 64'd4846351620;
  localparam logic [63:0] ONE_Q30          = 64'd1073741824;
  localparam logic [63:0] SPLIT_Q28        = 64'd939524096;
  localparam int          RANDOM_ITEMS     = 1130;
  localparam int          QUIET_ITEMS      = 100;
  localparam longint      CYCLE_LIMIT      = 64'd15000000;

  // erf/erfc predictor and store of expected results
  class erf_scoreboard;
    typedef struct {
      logic [31:0] erf;
      logic [31:0] erfc;
    } erf_pair_t;

    logic [63:0] exp_tab[257];
    erf_pair_t   pending[$];
    int          errors;

    function new();
      logic [127:0] p;
      errors     = 0;
      exp_tab[0] = 64'd1 << 32;
      for (int k = 1; k <= 256; k++) begin
        p          = {64'd0, exp_tab[k-1]} * {64'd0, EXP_STEP_Q32} + (128'd1 << 31);
        exp_tab[k] = p[95:32];
      end
    endfunction

    // (a*b) >> s, kept to 64 bits
    function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> s;
      return p[63:0];
    endfunction

    // e^(-t), Q.32 in and out
    function logic [63:0] exp_neg(logic [63:0] t);
      logic [63:0] scale, v, frac;
      int          k;
      scale = 64'd1 << 32;
      for (int n = 0; n < 4 && t >= (64'd16 << 32); n++) begin
        t     = t - (64'd16 << 32);
        scale = mul_shift(scale, exp_tab[256], 32);
      end
      if (t >= (64'd16 << 32)) return 64'd0;
      k    = int'(t >> 28);
      frac = t & ((64'd1 << 28) - 1);
      v    = exp_tab[k] - (((exp_tab[k] - exp_tab[k+1]) * frac) >> 28);
      return mul_shift(v, scale, 32);
    endfunction

    function erf_pair_t predict(logic [31:0] x);
      erf_pair_t          res;
      logic               neg;
      logic [63:0]        ax, x2, e, mag, r, sum, t1, t2, m, dv, p, q, c;
      logic signed [63:0] asum, erf;
      neg = x[31];
      ax  = neg ? {32'd0, (~x + 32'd1)} : {32'd0, x};
      // most negative argument: |x| is exactly 8
      if (ax == 0 && neg) ax = 64'd1 << 31;
      x2 = (ax * ax) >> 24;
      e  = exp_neg(x2);
      if (ax < SPLIT_Q28) begin
        // power series with early stop at one output LSB
        sum = 64'd1 << 32;
        r   = 64'd1 << 32;
        for (int i = 1; i <= SERIES_TERMS; i++) begin
          r   = mul_shift(r, x2, 31) / 64'(2 * i + 1);
          sum = sum + r;
          if (r <= (sum >> 30)) break;
        end
        t1  = ax * e;
        t2  = mul_shift(t1, sum, 32);
        mag = mul_shift(t2, TWO_SQRTPI_Q32, 62);
        if (mag > ONE_Q30) mag = ONE_Q30;
        erf = neg ? -$signed(mag) : $signed(mag);
      end else begin
        // asymptotic expansion of erfc(|x|)
        asum = 64'sd1 << 32;
        m    = 64'd1 << 32;
        dv   = x2 >> 12;
        for (int i = 1; i <= ASYMPTOTIC_TERMS; i++) begin
          m = ((m * 64'(2 * i - 1)) << 19) / dv;
          if (i & 1) asum = asum - $signed(m);
          else       asum = asum + $signed(m);
        end
        if (asum < 0) asum = 0;
        p = mul_shift(e, asum, 32);
        q = (p << 30) / ax;
        c = mul_shift(q, TWO_SQRTPI_Q32, 37);
        if (c > ONE_Q30) c = ONE_Q30;
        erf = neg ? $signed(c) - $signed(ONE_Q30) : $signed(ONE_Q30) - $signed(c);
      end
      res.erf  = erf[31:0];
      res.erfc = 32'($signed(ONE_Q30) - erf);
      return res;
    endfunction

    function void note_request(logic [31:0] x);
      pending.insert(pending.size(), predict(x));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] erf, logic [31:0] erfc);
      erf_pair_t want;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending.pop_front();
        if (erf !== want.erf)
          report($sformatf("erf got %h want %h", erf, want.erf));
        if (erfc !== want.erfc)
          report($sformatf("erfc got %h want %h", erfc, want.erfc));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [31:0] x_value_i;
  logic               done_o;
  logic signed [31:0] erf_value_o;
  logic [31:0]        erfc_value_o;
  longint             cycles;
  bit                 quiet;
  erf_scoreboard      sb;

  error_function_series #(
    .SERIES_TERMS    (SERIES_TERMS),
    .ASYMPTOTIC_TERMS(ASYMPTOTIC_TERMS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .x_value_i   (x_value_i),
    .done_o      (done_o),
    .erf_value_o (erf_value_o),
    .erfc_value_o(erfc_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watch accepted requests and results; cycle limit
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_request(x_value_i);
      if (done_o) sb.check_result(erf_value_o, erfc_value_o);
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("error_function_series_tb: errors");
      $finish;
    end
  end

  // one request; sometimes a random gap before it unless in the quiet tail
  task send_arg(logic [31:0] x);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start     <= 1'b1;
    x_value_i <= x;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function logic [31:0] random_arg();
    logic [31:0] x;
    x = $urandom();
    case ($urandom_range(0, 4))
      0:       x = $signed(x) >>> $urandom_range(1, 28);         // small magnitudes
      1:       x = 32'(SPLIT_Q28) + 32'($urandom_range(0, 64)) - 32'd32; // near the split
      2:       x = -(32'(SPLIT_Q28)) + 32'($urandom_range(0, 64)) - 32'd32;
      default: ;
    endcase
    return x;
  endfunction

  initial begin
    logic [31:0] directed[$];
    sb        = new();
    cycles    = 0;
    quiet     = 1'b0;
    start     = 1'b0;
    x_value_i = '0;
    rst_ni    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero, extremes, series/asymptotic boundary, large exponent arguments
    directed = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0001, 32'(SPLIT_Q28), 32'(SPLIT_Q28) - 32'd1,
                 -(32'(SPLIT_Q28)), -(32'(SPLIT_Q28)) + 32'd1, 32'h1000_0000,
                 32'hF000_0000, 32'h2000_0000, 32'h0000_1000, 32'h4000_0000,
                 32'hC000_0000, 32'h6000_0000, 32'h4AAA_AAAA, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h0800_0000, 32'h3000_0000};
    foreach (directed[i]) send_arg(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      send_arg(random_arg());
    end
    start <= 1'b0;

    // wait so the last request is surely noted, then drain
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.pending.size() != 0) sb.report("expected results left over");
    if (sb.errors == 0) begin
      $display("error_function_series_tb: clean");
    end else begin
      $display("error_function_series_tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/efs_pkg.sv
hdl/efs_mul.sv
hdl/efs_div.sv
hdl/efs_datapath.sv
hdl/efs_ctrl.sv
hdl/error_function_series.sv
test/error_function_series_tb.sv
